// ===== src/kwsd_pkg.sv =====
package kwsd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned TableAw    = $clog2(TableDepth);

  localparam logic [ByteW-1:0] FirstLabelRst = 8'd97;  // 'a'
  localparam logic [ByteW-1:0] SkipCharRst   = 8'd32;  // ' '

  typedef enum logic {
    RegFirstLabel = 1'b0,
    RegSkipChar   = 1'b1
  } reg_idx_e;

  typedef enum logic {
    CmdKey = 1'b0,
    CmdMsg = 1'b1
  } cmd_e;

endpackage

// ===== src/kwsd_ram.sv =====
module kwsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/keyword_substitution_decoder.sv =====
// Keyword substitution decoder. Key beats (tuser cmd = 0) build a 256-entry
// substitution table: each distinct key byte other than the skip byte takes
// the next label, starting at first_label and counting modulo 256; a key beat
// with new_key set first empties the table and restarts the labels. Message
// beats (cmd = 1) give one output beat each: the skip byte unchanged,
// otherwise the table entry of the byte, zero if unmapped. Key beats give no
// output. The block takes one beat per clock cycle unless a full output
// stalls a message beat; message beats pass the s1 and then the output
// register. The table is a 256x8 RAM with one read and one write port, read
// as a beat is accepted and written back in the next cycle, with a one-entry
// bypass for a read of the entry just written. A flip-flop per entry marks
// it as written, so reset and new_key empty the table at once and no
// clearing pass is needed. Write first_label and skip_char only while idle.
module keyword_substitution_decoder
  import kwsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write port
  input  logic             cfg_we_i,
  input  logic             cfg_addr_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  // input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]       s_axis_tuser,   // [0] cmd, [1] new_key
  // output stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata    // [7:0] decoded_byte
);

  logic [ByteW-1:0] first_label_q, first_label_d;
  logic [ByteW-1:0] skip_char_q, skip_char_d;
  logic [ByteW-1:0] next_label_q, next_label_d;

  logic             s1_valid_q, s1_valid_d;
  cmd_e             s1_cmd_q;
  logic             s1_new_key_q;
  logic [ByteW-1:0] s1_byte_q;

  logic [TableDepth-1:0] valid_q, valid_d;

  logic               fwd_vld_q, fwd_vld_d;
  logic [TableAw-1:0] fwd_addr_q;
  logic [ByteW-1:0]   fwd_data_q;

  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_data_q;

  logic             accept, out_ready, s1_adv, s1_is_key, clear, out_load;
  logic             tbl_we;
  logic [ByteW-1:0] ram_rdata, entry, label;

  // configuration registers
  always_comb begin
    first_label_d = first_label_q;
    skip_char_d   = skip_char_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        RegFirstLabel: first_label_d = cfg_wdata_i;
        RegSkipChar:   skip_char_d   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_is_key     = (s1_cmd_q == CmdKey);
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && (s1_is_key || out_ready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = s1_valid_q && !s1_is_key && out_ready;
  assign clear         = s1_is_key && s1_new_key_q;

  kwsd_ram #(
    .Width (ByteW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (s1_byte_q[TableAw-1:0]),
    .wdata_i (label),
    .re_i    (accept),
    .raddr_i (s_axis_tdata[TableAw-1:0]),
    .rdata_o (ram_rdata)
  );

  // current entry: empty after a clear, bypassed if just written
  always_comb begin
    if (clear || !valid_q[s1_byte_q[TableAw-1:0]]) begin
      entry = '0;
    end else if (fwd_vld_q && (fwd_addr_q == s1_byte_q[TableAw-1:0])) begin
      entry = fwd_data_q;
    end else begin
      entry = ram_rdata;
    end
  end

  assign label  = clear ? first_label_q : next_label_q;
  assign tbl_we = s1_adv && s1_is_key && (s1_byte_q != skip_char_q) && (entry == '0);

  always_comb begin
    next_label_d = next_label_q;
    valid_d      = valid_q;
    fwd_vld_d    = fwd_vld_q;
    if (s1_adv) begin
      fwd_vld_d = tbl_we;
      if (s1_is_key) begin
        next_label_d = tbl_we ? label + 8'd1 : label;
      end
      if (clear) begin
        valid_d = '0;
      end
      if (tbl_we) begin
        valid_d[s1_byte_q[TableAw-1:0]] = 1'b1;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_label_q <= FirstLabelRst;
      skip_char_q   <= SkipCharRst;
      next_label_q  <= FirstLabelRst;
      s1_valid_q    <= 1'b0;
      valid_q       <= '0;
      fwd_vld_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      first_label_q <= first_label_d;
      skip_char_q   <= skip_char_d;
      next_label_q  <= next_label_d;
      s1_valid_q    <= s1_valid_d;
      valid_q       <= valid_d;
      fwd_vld_q     <= fwd_vld_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q     <= cmd_e'(s_axis_tuser[0]);
      s1_new_key_q <= s_axis_tuser[1];
      s1_byte_q    <= s_axis_tdata[ByteW-1:0];
    end
    if (s1_adv) begin
      fwd_addr_q <= s1_byte_q[TableAw-1:0];
      fwd_data_q <= label;
    end
    if (out_load) begin
      out_data_q <= (s1_byte_q == skip_char_q) ? skip_char_q : entry;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // stall only behind a message beat held up by a full output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && (s1_cmd_q == CmdMsg) && m_axis_tvalid)
    else $error("input stalled without a blocked message beat");

  a_write_key_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> s1_valid_q && (s1_cmd_q == CmdKey))
    else $error("table written by a non-key beat");

  a_write_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |=> valid_q[fwd_addr_q] && fwd_vld_q)
    else $error("written entry not marked or not bypassed");

  a_clear_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && clear && !tbl_we |=> next_label_q == $past(first_label_q))
    else $error("labels not restarted on new key");

endmodule

// ===== dv/kwsd_decode_check.sv =====
`timescale 1ns / 100ps

module kwsd_decode_check
  import kwsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_addr_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]       s_axis_tuser,   // [0] cmd, [1] new_key
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [7:0]       m_axis_tdata,   // [7:0] decoded_byte
  output int               mismatch_o,
  output int               pending_o
);

  logic [ByteW-1:0] label_map [TableDepth];
  logic [ByteW-1:0] label_next;
  logic [ByteW-1:0] first_label_q;
  logic [ByteW-1:0] skip_q;
  logic [ByteW-1:0] decoded_q [$];
  logic [ByteW-1:0] want_byte;
  int               mismatch_cnt;

  task automatic note_mismatch(input logic [ByteW-1:0] want, input logic [7:0] got,
                               input bit orphan);
    if (mismatch_cnt < 10) begin
      if (orphan) $display("%0t: decoded beat %02h with nothing outstanding", $realtime, got);
      else $display("%0t: decoded_byte expected %02h, got %02h", $realtime, want, got);
    end
    mismatch_cnt++;
  endtask

  // Key beats build the table, message beats queue their translation.
  task automatic absorb_beat(input cmd_e cmd, input logic fresh, input logic [ByteW-1:0] b);
    if (cmd == CmdKey) begin
      if (fresh) begin
        for (int i = 0; i < TableDepth; i++) label_map[i] = '0;
        label_next = first_label_q;
      end
      if (b != skip_q && label_map[b] == '0) begin
        label_map[b] = label_next;
        label_next   = label_next + 1'b1;
      end
    end else begin
      decoded_q = {decoded_q, ((b == skip_q) ? skip_q : label_map[b])};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableDepth; i++) label_map[i] = '0;
      first_label_q = FirstLabelRst;
      skip_q        = SkipCharRst;
      label_next    = FirstLabelRst;
      decoded_q.delete();
      mismatch_cnt  = 0;
      mismatch_o   <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          note_mismatch('0, m_axis_tdata, 1'b1);
        end else begin
          want_byte = decoded_q.pop_front();
          if (m_axis_tdata !== want_byte) note_mismatch(want_byte, m_axis_tdata, 1'b0);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        absorb_beat(cmd_e'(s_axis_tuser[0]), s_axis_tuser[1], s_axis_tdata);
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_addr_i))
          RegFirstLabel: first_label_q = cfg_wdata_i;
          RegSkipChar:   skip_q        = cfg_wdata_i;
          default: ;
        endcase
      end
      mismatch_o <= mismatch_cnt;
      pending_o  <= decoded_q.size();
    end
  end

endmodule

// ===== dv/tb_keyword_substitution_decoder.sv =====
`timescale 1ns / 100ps

module tb_keyword_substitution_decoder;
  import kwsd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic             cfg_addr_i    = 1'b0;
  logic [ByteW-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;   // [7:0] data_byte
  logic [1:0]       s_axis_tuser  = '0;   // [0] cmd, [1] new_key
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;         // [7:0] decoded_byte

  int               mismatch_cnt;
  int               pending_cnt;
  int               cycle_cnt     = 0;
  int               tx_idle_pct   = 0;
  int               rx_stall_pct  = 0;
  int               hold_left     = 0;
  bit               hold_start    = 1'b0;
  logic [ByteW-1:0] skip_cur      = SkipCharRst;

  keyword_substitution_decoder u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  kwsd_decode_check u_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .mismatch_o(mismatch_cnt), .pending_o(pending_cnt)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[keyword_substitution_decoder] ERROR");
      $finish;
    end
  end

  // Output side: random back-pressure, or a long hold-off when asked.
  always @(negedge clk_i) begin
    if (hold_start) begin
      hold_left  = HoldCycles;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic int pick_gap();
    int g;
    g = 0;
    while (g < 40 && $urandom_range(99) < tx_idle_pct) g++;
    return g;
  endfunction

  task automatic send_beat(input cmd_e cmd, input logic fresh, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= {fresh, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drop valid and hold until every decoded beat is out, then let key
  // write-backs settle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [ByteW-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == RegSkipChar) skip_cur = v;
  endtask

  // Mostly a fresh key followed by a message drawn from it; the rest is noise.
  task automatic run_traffic(input int n);
    int               sent;
    int               klen;
    int               mlen;
    int               pick;
    logic [7:0]       b;
    logic [7:0]       key_bytes [$];
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 80) begin
        klen = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        key_bytes.delete();
        for (int i = 0; i < klen; i++) begin
          pick = $urandom_range(99);
          if (key_bytes.size() != 0 && pick < 10)
            b = key_bytes[$urandom_range(key_bytes.size() - 1)];
          else if (pick < 18)
            b = skip_cur;
          else
            b = 8'($urandom_range(255));
          send_beat(CmdKey, (i == 0), b);
          key_bytes = {key_bytes, b};
          sent++;
        end
        mlen = $urandom_range(1, 12);
        for (int i = 0; i < mlen; i++) begin
          pick = $urandom_range(99);
          if (pick < 70) b = key_bytes[$urandom_range(key_bytes.size() - 1)];
          else if (pick < 80) b = skip_cur;
          else b = 8'($urandom_range(255));
          send_beat(CmdMsg, ($urandom_range(3) == 0), b);
          sent++;
        end
      end else begin
        send_beat(cmd_e'($urandom_range(1)), 1'($urandom_range(1)),
                  8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Table as left by reset, then a key byte before any new key.
    send_beat(CmdMsg, 1'b0, 8'h41);
    send_beat(CmdMsg, 1'b0, 8'h20);
    send_beat(CmdKey, 1'b0, 8'h6b);
    // Fresh key: extremes, skip byte ignored, a repeat keeps its label.
    send_beat(CmdKey, 1'b1, 8'h00);
    send_beat(CmdKey, 1'b0, 8'hff);
    send_beat(CmdKey, 1'b0, 8'h20);
    send_beat(CmdKey, 1'b0, 8'h00);
    send_beat(CmdKey, 1'b0, 8'h80);
    send_beat(CmdMsg, 1'b0, 8'h00);
    send_beat(CmdMsg, 1'b0, 8'hff);
    send_beat(CmdMsg, 1'b0, 8'h20);
    send_beat(CmdMsg, 1'b0, 8'h80);
    send_beat(CmdMsg, 1'b0, 8'h6b);
    send_beat(CmdMsg, 1'b0, 8'h55);
    // new_key on a message beat is ignored.
    send_beat(CmdMsg, 1'b1, 8'hff);
    drain();

    // first_label change leaves the running counter alone until a new key;
    // then labels wrap through zero; a byte given label zero is remapped on its repeat.
    write_reg(RegFirstLabel, 8'd254);
    send_beat(CmdKey, 1'b0, 8'h10);
    send_beat(CmdKey, 1'b1, 8'h01);
    send_beat(CmdKey, 1'b0, 8'h02);
    send_beat(CmdKey, 1'b0, 8'h03);
    send_beat(CmdKey, 1'b0, 8'h03);
    send_beat(CmdMsg, 1'b0, 8'h01);
    send_beat(CmdMsg, 1'b0, 8'h02);
    send_beat(CmdMsg, 1'b0, 8'h03);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 0;  rx_stall_pct = 0;
          write_reg(RegFirstLabel, FirstLabelRst);
          write_reg(RegSkipChar, SkipCharRst);
        end
        1: begin
          tx_idle_pct = 83; rx_stall_pct = 0;
          write_reg(RegFirstLabel, 8'd255);
          write_reg(RegSkipChar, 8'd0);
        end
        2: begin
          tx_idle_pct = 0;  rx_stall_pct = 83;
          write_reg(RegFirstLabel, 8'd0);
          write_reg(RegSkipChar, 8'd255);
        end
        default: begin
          tx_idle_pct = 29; rx_stall_pct = 29;
          write_reg(RegFirstLabel, 8'($urandom_range(255)));
          write_reg(RegSkipChar, 8'($urandom_range(255)));
        end
      endcase
      if (ph == 0) begin
        run_traffic(40);
        // Output held off while input keeps coming, so the block backs up.
        hold_start = 1'b1;
        run_traffic(60);
      end else begin
        run_traffic(100);
      end
      drain();
    end

    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("[keyword_substitution_decoder] OK");
    end else begin
      $display("[keyword_substitution_decoder] ERROR");
    end
    $finish;
  end

endmodule
